FILE: src/nvg_pkg.sv
// Shared constants, types and the square-root table of the voter event engine.
package nvg_pkg;

  localparam int MAX_POPULATION = 1024;
  localparam int RATE_FRAC_BITS = 16;
  localparam int UP_LIMIT       = 1023;

  localparam int POP_W   = 11;
  localparam int ZEAL_W  = 10;
  localparam int EXP_W   = 15;
  localparam int CNT_W   = 10;
  localparam int HOR_W   = 16;
  localparam int RND_W   = 32;
  localparam int TIME_W  = 48;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  // Fixed-point layout of the internal arithmetic.
  localparam int LOG_FRAC   = 24;
  localparam int LOG_W      = 28;
  localparam int LW_W       = 30;
  localparam int MANT_W     = 31;
  localparam int ROOT_W     = 30;
  localparam int RATE_SHIFT = 30 - RATE_FRAC_BITS;
  localparam int RATE_W     = 26;
  localparam int TOT_W      = 27;
  localparam int WAIT_SHIFT = RATE_FRAC_BITS - 8;
  localparam int DVD_W      = LW_W + WAIT_SHIFT;

  localparam logic [MANT_W-1:0] ONE_Q30 = MANT_W'(1) << 30;
  localparam logic [ROOT_W-1:0] LN2_Q30 = 30'd744261118;

  localparam logic [POP_W-1:0]  POPULATION_RST = 11'd100;
  localparam logic [ZEAL_W-1:0] ZEALOTS_RST    = 10'd30;
  localparam logic [EXP_W-1:0]  EXPONENT_RST   = 15'd12288;
  localparam logic [CNT_W-1:0]  START_RST      = 10'd1;
  localparam logic [HOR_W-1:0]  HORIZON_RST    = 16'd1000;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_POPULATION = 3'd0,
    REG_ZEALOTS    = 3'd1,
    REG_EXPONENT   = 3'd2,
    REG_START      = 3'd3,
    REG_HORIZON    = 3'd4
  } cfg_reg_t;

  // Entry i holds 2^(-2^-i) in Q0.30; each is the integer square root of the one before.
  typedef logic [LOG_FRAC:0][ROOT_W-1:0] root_tab_t;

  function automatic root_tab_t build_root_tab();
    root_tab_t   t;
    logic [63:0] v;
    logic [63:0] r;
    logic [63:0] b;
    t = '0;
    t[0] = 30'h2000_0000;
    for (int i = 1; i <= LOG_FRAC; i++) begin
      v = {4'b0, t[i-1], 30'b0};
      r = '0;
      b = 64'h4000_0000_0000_0000;
      for (int k = 0; k < 32; k++) begin
        if (v >= r + b) begin
          v = v - (r + b);
          r = (r >> 1) + b;
        end else begin
          r = r >> 1;
        end
        b = b >> 2;
      end
      t[i] = r[ROOT_W-1:0];
    end
    return t;
  endfunction

  localparam root_tab_t ROOT_TAB = build_root_tab();

endpackage

FILE: src/nvg_if.sv
// Handshake interfaces for the input, result and configuration channels.
interface nvg_in_if;
  import nvg_pkg::*;
  logic             valid;
  logic             ready;
  logic [RND_W-1:0] wait_random;
  logic [RND_W-1:0] choice_random;
  logic             restart;
  modport source (output valid, wait_random, choice_random, restart, input ready);
  modport sink   (input valid, wait_random, choice_random, restart, output ready);
endinterface

interface nvg_out_if;
  import nvg_pkg::*;
  logic              valid;
  logic              ready;
  logic [TIME_W-1:0] elapsed_time;
  logic [CNT_W-1:0]  up_count;
  logic              absorbed;
  logic              horizon_reached;
  logic              zero_rate;
  modport source (output valid, elapsed_time, up_count, absorbed, horizon_reached,
                  zero_rate, input ready);
  modport sink   (input valid, elapsed_time, up_count, absorbed, horizon_reached,
                  zero_rate, output ready);
endinterface

interface nvg_cfg_if;
  import nvg_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

FILE: src/nvg_div.sv
// Restoring divider that produces one quotient bit per cycle.
module nvg_div (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [nvg_pkg::DVD_W-1:0]  dividend,
  input  logic [nvg_pkg::TOT_W-1:0]  divisor,
  output logic                       done,
  output logic [nvg_pkg::DVD_W-1:0]  quotient
);
  import nvg_pkg::*;

  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic [5:0]        cnt_r, cnt_nxt;
  logic [DVD_W-1:0]  quo_r, quo_nxt;
  logic [TOT_W-1:0]  rem_r, rem_nxt;
  logic [TOT_W:0]    trial;
  logic [TOT_W:0]    diff;
  logic              ge;

  assign trial = {rem_r, quo_r[DVD_W-1]};
  assign ge    = trial >= {1'b0, divisor};
  assign diff  = trial - {1'b0, divisor};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      quo_nxt  = dividend;
      rem_nxt  = '0;
    end else if (busy_r) begin
      rem_nxt = ge ? diff[TOT_W-1:0] : trial[TOT_W-1:0];
      quo_nxt = {quo_r[DVD_W-2:0], ge};
      cnt_nxt = cnt_r + 6'd1;
      if (cnt_r == 6'(DVD_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cnt_r <= cnt_nxt;
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

FILE: src/nonlinear_voter_gillespie_step.sv
// Top level: one Gillespie event of the nonlinear voter model with zealots per transaction.
//
// Channels: in_ch carries two uniform random words and a restart flag; out_ch returns
// the elapsed time, the up count and three status flags after the event; cfg_ch writes
// the five model registers (population, zealots, exponent, start count, horizon) and is
// always ready. Registers are to be written only while no transaction is in flight.
// A transaction is accepted when valid and ready are both high on a rising clock edge.
// Each input transaction yields exactly one result transaction.
// Four 24-step logarithms, two 24-step powers and a 38-step division run on one shared
// 32x32 multiplier and a bit-serial divider; the logarithm squarings take the largest
// share of the work. One item is processed at a time.
// A finished result sits in an output register; the engine takes the next item while
// that result waits. If a second result is done before the first was taken, the engine
// holds it and stays not ready until the receiver takes the first.
// Reset (rst_n low, synchronous) loads the register defaults, sets the up count to the
// default start count, clears the time and the finished flag, and empties the output.
module nonlinear_voter_gillespie_step (
  input  logic        clk,
  input  logic        rst_n,
  nvg_in_if.sink      in_ch,
  nvg_out_if.source   out_ch,
  nvg_cfg_if.sink     cfg_ch
);
  import nvg_pkg::*;

  typedef enum logic [11:0] {
    S_IDLE     = 12'b0000_0000_0001,
    S_LOG_NORM = 12'b0000_0000_0010,
    S_LOG_SQ   = 12'b0000_0000_0100,
    S_PW_Y     = 12'b0000_0000_1000,
    S_PW_MUL   = 12'b0000_0001_0000,
    S_PW_SHIFT = 12'b0000_0010_0000,
    S_RATE     = 12'b0000_0100_0000,
    S_LN       = 12'b0000_1000_0000,
    S_CHOOSE   = 12'b0001_0000_0000,
    S_DIV      = 12'b0010_0000_0000,
    S_UPDATE   = 12'b0100_0000_0000,
    S_HOLD     = 12'b1000_0000_0000
  } state_t;

  // Which operand the logarithm sequence is working on.
  typedef enum logic [1:0] {
    LS_B  = 2'd0,
    LS_A1 = 2'd1,
    LS_A2 = 2'd2,
    LS_W  = 2'd3
  } log_sel_t;

  // Position of the leading one; zero for a zero word.
  function automatic logic [4:0] msb_pos(input logic [RND_W-1:0] x);
    logic [4:0] pos;
    pos = '0;
    for (int k = 0; k < RND_W; k++) begin
      if (x[k]) pos = 5'(k);
    end
    return pos;
  endfunction

  // Configuration registers.
  logic [POP_W-1:0]  pop_r;
  logic [ZEAL_W-1:0] zeal_r;
  logic [EXP_W-1:0]  expq_r;
  logic [CNT_W-1:0]  start_r;
  logic [HOR_W-1:0]  hor_r;

  // Architectural state.
  state_t            state_r, state_nxt;
  logic [CNT_W-1:0]  up_cnt_r, up_cnt_nxt;
  logic [TIME_W-1:0] time_r, time_nxt;
  logic              fin_r, fin_nxt;
  logic              out_valid_r, out_valid_nxt;

  // Working registers of the event computation.
  logic [RND_W-1:0]  w_r, w_nxt;
  logic [RND_W-1:0]  c_r, c_nxt;
  log_sel_t          sel_r, sel_nxt;
  logic              pw_tm_r, pw_tm_nxt;
  logic [MANT_W-1:0] m_r, m_nxt;
  logic [4:0]        pos_r, pos_nxt;
  logic [LOG_FRAC-1:0] fr_r, fr_nxt;
  logic [4:0]        cnt_r, cnt_nxt;
  logic [LOG_W-1:0]  lb_r, lb_nxt;
  logic [LOG_W-1:0]  la1_r, la1_nxt;
  logic [LOG_W-1:0]  la2_r, la2_nxt;
  logic [LW_W-1:0]   lw_r, lw_nxt;
  logic [6:0]        ip_r, ip_nxt;
  logic [LOG_FRAC-1:0] f_r, f_nxt;
  logic [MANT_W-1:0] acc_r, acc_nxt;
  logic [MANT_W-1:0] pw_r, pw_nxt;
  logic [RATE_W-1:0] tp_r, tp_nxt;
  logic [TOT_W-1:0]  tot_r, tot_nxt;
  logic [LW_W-1:0]   e_r, e_nxt;
  logic              up_r, up_nxt;
  logic              zr_r, zr_nxt;

  // Output payload registers.
  logic [TIME_W-1:0] o_time_r, o_time_nxt;
  logic [CNT_W-1:0]  o_cnt_r, o_cnt_nxt;
  logic              o_abs_r, o_abs_nxt;
  logic              o_hor_r, o_hor_nxt;
  logic              o_zr_r, o_zr_nxt;

  // Clamped model parameters, derived from the configuration.
  logic [POP_W-1:0]  nn;
  logic [POP_W-1:0]  nn_m1;
  logic [POP_W-1:0]  zz;
  logic [POP_W-1:0]  s_full;
  logic [CNT_W-1:0]  s_cnt;
  logic [CNT_W-1:0]  b_val;
  logic [TIME_W-1:0] h_val;

  always_comb begin
    nn = pop_r;
    if (pop_r < POP_W'(2)) nn = POP_W'(2);
    else if (pop_r > POP_W'(MAX_POPULATION)) nn = POP_W'(MAX_POPULATION);
    nn_m1 = nn - POP_W'(1);
    zz = {1'b0, zeal_r};
    if (zz > nn_m1) zz = nn_m1;
    if (nn - zz > POP_W'(UP_LIMIT)) zz = nn - POP_W'(UP_LIMIT);
    s_full = nn - zz;
    s_cnt  = s_full[CNT_W-1:0];
    b_val  = nn_m1[CNT_W-1:0];
    h_val  = {hor_r, 32'b0} >> (HOR_W + 16 - RATE_FRAC_BITS);
  end

  // Power bases, clamped to the common denominator N-1.
  logic [POP_W-1:0] a1_raw;
  logic [CNT_W-1:0] a1_val;
  logic [CNT_W-1:0] a2_raw;
  logic [CNT_W-1:0] a2_val;
  logic [CNT_W-1:0] a_cur;
  logic [CNT_W-1:0] cnt_val;

  always_comb begin
    a1_raw  = {1'b0, up_cnt_r} + zz;
    a1_val  = (a1_raw > {1'b0, b_val}) ? b_val : a1_raw[CNT_W-1:0];
    a2_raw  = s_cnt - up_cnt_r;
    a2_val  = (a2_raw > b_val) ? b_val : a2_raw;
    a_cur   = pw_tm_r ? a2_val : a1_val;
    cnt_val = pw_tm_r ? up_cnt_r : a2_raw;
  end

  // Logarithm operand and its normalized mantissa.
  logic [RND_W-1:0] log_x;
  logic [4:0]       log_pos;
  logic [RND_W-1:0] norm_x;

  always_comb begin
    case (sel_r)
      LS_B:    log_x = RND_W'(b_val);
      LS_A1:   log_x = RND_W'(a1_val);
      LS_A2:   log_x = RND_W'(a2_val);
      LS_W:    log_x = w_r;
      default: log_x = '0;
    endcase
    log_pos = msb_pos(log_x);
    norm_x  = log_x << (5'd31 - log_pos);
  end

  // Exponent argument: log2(N-1) - log2(a), never negative.
  logic [LOG_W:0]   d_full;
  logic [LOG_W-1:0] d_pos;

  always_comb begin
    d_full = {1'b0, lb_r} - {1'b0, (pw_tm_r ? la2_r : la1_r)};
    d_pos  = d_full[LOG_W] ? '0 : d_full[LOG_W-1:0];
  end

  // The shared multiplier; every result taken from its product is captured in a register.
  logic [31:0] mul_a;
  logic [31:0] mul_b;
  logic [63:0] mul_p;

  always_comb begin
    case (state_r)
      S_LOG_SQ: begin
        mul_a = {1'b0, m_r};
        mul_b = {1'b0, m_r};
      end
      S_PW_Y: begin
        mul_a = 32'(expq_r);
        mul_b = 32'(d_pos);
      end
      S_PW_MUL: begin
        mul_a = {1'b0, acc_r};
        mul_b = 32'(ROOT_TAB[cnt_r + 5'd1]);
      end
      S_RATE: begin
        mul_a = 32'(cnt_val);
        mul_b = {1'b0, pw_r};
      end
      S_LN: begin
        mul_a = 32'(lw_r);
        mul_b = 32'(LN2_Q30);
      end
      S_CHOOSE: begin
        mul_a = c_r;
        mul_b = 32'(tot_r);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_p = mul_a * mul_b;

  // One squaring step of the logarithm.
  logic [31:0]         sq;
  logic                sq_bit;
  logic [MANT_W-1:0]   sq_m;
  logic [LOG_FRAC-1:0] sq_fr;

  always_comb begin
    sq     = mul_p[61:30];
    sq_bit = sq[31];
    sq_m   = sq_bit ? sq[31:1] : sq[30:0];
    sq_fr  = {fr_r[LOG_FRAC-2:0], sq_bit};
  end

  // Rate value and the final event arithmetic.
  logic [RATE_W-1:0] rate_v;
  logic              div_done;
  logic [DVD_W-1:0]  div_q;
  logic [TIME_W:0]   time_sum;
  logic [TIME_W-1:0] time_adv;
  logic [CNT_W-1:0]  n_move;
  logic              zr_now;

  always_comb begin
    rate_v   = (cnt_val == '0) ? '0 : mul_p[RATE_SHIFT +: RATE_W];
    time_sum = {1'b0, time_r} + (TIME_W + 1)'(div_q);
    time_adv = time_sum[TIME_W] ? {TIME_W{1'b1}} : time_sum[TIME_W-1:0];
    if (up_r) n_move = up_cnt_r + CNT_W'(1);
    else if (up_cnt_r != '0) n_move = up_cnt_r - CNT_W'(1);
    else n_move = up_cnt_r;
    zr_now   = (up_cnt_r < s_cnt) && (tot_r == '0);
  end

  nvg_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (state_r == S_CHOOSE),
    .dividend ({e_r, WAIT_SHIFT'(0)}),
    .divisor  (tot_r),
    .done     (div_done),
    .quotient (div_q)
  );

  logic             in_acc;
  logic [CNT_W-1:0] n_load;
  logic [CNT_W-1:0] n_sat;

  assign in_ch.ready = (state_r == S_IDLE);
  assign in_acc      = in_ch.valid && in_ch.ready;

  always_comb begin
    n_load = in_ch.restart ? start_r : up_cnt_r;
    n_sat  = (n_load > s_cnt) ? s_cnt : n_load;
  end

  // Sequencer.
  always_comb begin
    state_nxt     = state_r;
    up_cnt_nxt    = up_cnt_r;
    time_nxt      = time_r;
    fin_nxt       = fin_r;
    out_valid_nxt = out_valid_r;
    w_nxt   = w_r;
    c_nxt   = c_r;
    sel_nxt = sel_r;
    pw_tm_nxt = pw_tm_r;
    m_nxt   = m_r;
    pos_nxt = pos_r;
    fr_nxt  = fr_r;
    cnt_nxt = cnt_r;
    lb_nxt  = lb_r;
    la1_nxt = la1_r;
    la2_nxt = la2_r;
    lw_nxt  = lw_r;
    ip_nxt  = ip_r;
    f_nxt   = f_r;
    acc_nxt = acc_r;
    pw_nxt  = pw_r;
    tp_nxt  = tp_r;
    tot_nxt = tot_r;
    e_nxt   = e_r;
    up_nxt  = up_r;
    zr_nxt  = zr_r;
    o_time_nxt = o_time_r;
    o_cnt_nxt  = o_cnt_r;
    o_abs_nxt  = o_abs_r;
    o_hor_nxt  = o_hor_r;
    o_zr_nxt   = o_zr_r;

    if (out_valid_r && out_ch.ready) out_valid_nxt = 1'b0;

    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          // A restart takes effect before the event of the same transaction.
          up_cnt_nxt = n_sat;
          if (in_ch.restart) begin
            time_nxt = '0;
            fin_nxt  = 1'b0;
          end
          w_nxt     = (in_ch.wait_random == '0) ? RND_W'(1) : in_ch.wait_random;
          c_nxt     = in_ch.choice_random;
          sel_nxt   = LS_B;
          state_nxt = S_LOG_NORM;
        end
      end
      S_LOG_NORM: begin
        m_nxt     = norm_x[31:1];
        pos_nxt   = log_pos;
        fr_nxt    = '0;
        cnt_nxt   = '0;
        state_nxt = S_LOG_SQ;
      end
      S_LOG_SQ: begin
        m_nxt   = sq_m;
        fr_nxt  = sq_fr;
        cnt_nxt = cnt_r + 5'd1;
        if (cnt_r == 5'(LOG_FRAC - 1)) begin
          case (sel_r)
            LS_B: begin
              lb_nxt    = {pos_r[3:0], sq_fr};
              sel_nxt   = LS_A1;
              state_nxt = S_LOG_NORM;
            end
            LS_A1: begin
              la1_nxt   = {pos_r[3:0], sq_fr};
              sel_nxt   = LS_A2;
              state_nxt = S_LOG_NORM;
            end
            LS_A2: begin
              la2_nxt   = {pos_r[3:0], sq_fr};
              sel_nxt   = LS_W;
              state_nxt = S_LOG_NORM;
            end
            default: begin
              // The wait word is a fraction of 2^32, so its logarithm is negated here.
              lw_nxt    = {6'd32 - {1'b0, pos_r}, 24'b0} - LW_W'(sq_fr);
              pw_tm_nxt = 1'b0;
              state_nxt = S_PW_Y;
            end
          endcase
        end
      end
      S_PW_Y: begin
        ip_nxt    = mul_p[42:36];
        f_nxt     = mul_p[35:12];
        acc_nxt   = ONE_Q30;
        cnt_nxt   = '0;
        state_nxt = S_PW_MUL;
      end
      S_PW_MUL: begin
        if (f_r[LOG_FRAC-1]) acc_nxt = mul_p[60:30];
        f_nxt   = {f_r[LOG_FRAC-2:0], 1'b0};
        cnt_nxt = cnt_r + 5'd1;
        if (cnt_r == 5'(LOG_FRAC - 1)) state_nxt = S_PW_SHIFT;
      end
      S_PW_SHIFT: begin
        // A zero base gives zero, except that zero to the power zero is one.
        if (a_cur == '0) pw_nxt = (expq_r == '0) ? ONE_Q30 : '0;
        else if (ip_r >= 7'd31) pw_nxt = '0;
        else pw_nxt = acc_r >> ip_r[4:0];
        state_nxt = S_RATE;
      end
      S_RATE: begin
        if (!pw_tm_r) begin
          tp_nxt    = rate_v;
          pw_tm_nxt = 1'b1;
          state_nxt = S_PW_Y;
        end else begin
          tot_nxt   = {1'b0, tp_r} + {1'b0, rate_v};
          state_nxt = S_LN;
        end
      end
      S_LN: begin
        e_nxt     = mul_p[59:30];
        state_nxt = S_CHOOSE;
      end
      S_CHOOSE: begin
        // Exact test r2 * total <= T+ * 2^32.
        up_nxt    = mul_p <= {6'b0, tp_r, 32'b0};
        state_nxt = S_DIV;
      end
      S_DIV: begin
        if (div_done) state_nxt = S_UPDATE;
      end
      S_UPDATE: begin
        zr_nxt = zr_now;
        if (!fin_r) begin
          if (up_cnt_r >= s_cnt || time_r >= h_val || zr_now) begin
            fin_nxt = 1'b1;
          end else begin
            time_nxt   = time_adv;
            up_cnt_nxt = n_move;
            fin_nxt    = (n_move == s_cnt) || (time_adv >= h_val);
          end
        end
        state_nxt = S_HOLD;
      end
      S_HOLD: begin
        if (!out_valid_r || out_ch.ready) begin
          o_time_nxt    = time_r;
          o_cnt_nxt     = up_cnt_r;
          o_abs_nxt     = (up_cnt_r == s_cnt);
          o_hor_nxt     = (time_r >= h_val);
          o_zr_nxt      = zr_r;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Control and architectural state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      up_cnt_r    <= START_RST;
      time_r      <= '0;
      fin_r       <= 1'b0;
      out_valid_r <= 1'b0;
      pop_r       <= POPULATION_RST;
      zeal_r      <= ZEALOTS_RST;
      expq_r      <= EXPONENT_RST;
      start_r     <= START_RST;
      hor_r       <= HORIZON_RST;
    end else begin
      state_r     <= state_nxt;
      up_cnt_r    <= up_cnt_nxt;
      time_r      <= time_nxt;
      fin_r       <= fin_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_ch.valid && cfg_ch.ready) begin
        case (cfg_reg_t'(cfg_ch.index))
          REG_POPULATION: pop_r   <= cfg_ch.data[POP_W-1:0];
          REG_ZEALOTS:    zeal_r  <= cfg_ch.data[ZEAL_W-1:0];
          REG_EXPONENT:   expq_r  <= cfg_ch.data[EXP_W-1:0];
          REG_START:      start_r <= cfg_ch.data[CNT_W-1:0];
          REG_HORIZON:    hor_r   <= cfg_ch.data[HOR_W-1:0];
          default: ;
        endcase
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    w_r     <= w_nxt;
    c_r     <= c_nxt;
    sel_r   <= sel_nxt;
    pw_tm_r <= pw_tm_nxt;
    m_r     <= m_nxt;
    pos_r   <= pos_nxt;
    fr_r    <= fr_nxt;
    cnt_r   <= cnt_nxt;
    lb_r    <= lb_nxt;
    la1_r   <= la1_nxt;
    la2_r   <= la2_nxt;
    lw_r    <= lw_nxt;
    ip_r    <= ip_nxt;
    f_r     <= f_nxt;
    acc_r   <= acc_nxt;
    pw_r    <= pw_nxt;
    tp_r    <= tp_nxt;
    tot_r   <= tot_nxt;
    e_r     <= e_nxt;
    up_r    <= up_nxt;
    zr_r    <= zr_nxt;
    o_time_r <= o_time_nxt;
    o_cnt_r  <= o_cnt_nxt;
    o_abs_r  <= o_abs_nxt;
    o_hor_r  <= o_hor_nxt;
    o_zr_r   <= o_zr_nxt;
  end

  assign cfg_ch.ready           = 1'b1;
  assign out_ch.valid           = out_valid_r;
  assign out_ch.elapsed_time    = o_time_r;
  assign out_ch.up_count        = o_cnt_r;
  assign out_ch.absorbed        = o_abs_r;
  assign out_ch.horizon_reached = o_hor_r;
  assign out_ch.zero_rate       = o_zr_r;

endmodule
